### sv/axco_pkg.sv
// Package for the AND/XOR cursor overlay engine.
// Holds shared types, register indexes, opcodes and helper functions.
// No dependencies.
package axco_pkg;

    localparam int SIDE_BITS  = 6;
    localparam int MAX_SIDE   = 1 << SIDE_BITS;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int COORD_BITS = 16;
    localparam int PIX_BITS   = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_BITS     = 2;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_POS    = 3'd1,
        OP_BLIT   = 3'd2,
        OP_ERASE  = 3'd3,
        OP_LOCK   = 3'd4,
        OP_UNLOCK = 3'd5,
        OP_UNLOAD = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_ERASED  = 2'd1,
        ST_BLITTED = 2'd2
    } t_state;

    typedef enum logic [2:0] {
        REG_SCR_W = 3'd0,
        REG_SCR_H = 3'd1,
        REG_CUR_W = 3'd2,
        REG_CUR_H = 3'd3,
        REG_HOT_X = 3'd4,
        REG_HOT_Y = 3'd5,
        REG_BPP   = 3'd6
    } t_reg;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // classified item handed from front to back
    typedef struct packed {
        logic                  acc;
        logic                  load;
        logic                  blit;
        logic                  erase;
        logic                  hit;
        logic [ADDR_BITS-1:0]  addr;
        logic [PIX_BITS-1:0]   fp;
        logic [PIX_BITS-1:0]   xv;
        logic [PIX_BITS-1:0]   pm;
        t_coord                tx;
        t_coord                ty;
        logic [1:0]            state;
        t_coord                rl;
        t_coord                rt;
        t_coord                rr;
        t_coord                rb;
    } t_job;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        t_coord              tx;
        t_coord              ty;
        logic                we;
        logic                acc;
        logic [1:0]          state;
        t_coord              rl;
        t_coord              rt;
        t_coord              rr;
        t_coord              rb;
    } t_res;

    function automatic logic [PIX_BITS-1:0] pix_mask(input logic [2:0] bpp);
        case (bpp)
            3'd0, 3'd1: pix_mask = 32'h0000_00FF;
            3'd2:       pix_mask = 32'h0000_FFFF;
            3'd3:       pix_mask = 32'h00FF_FFFF;
            default:    pix_mask = 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [SIDE_BITS:0] side_lim(input logic [6:0] v);
        side_lim = (v > 7'(MAX_SIDE)) ? (SIDE_BITS+1)'(MAX_SIDE) : v[SIDE_BITS:0];
    endfunction

endpackage

### sv/and_xor_cursor_overlay_engine.sv
// AND/XOR cursor overlay engine, top level. Depends on axco_pkg, axco_front,
// axco_queue, axco_back. The result passes the queue write, the store read and the
// output register. Throughput: one item per cycle while i_stall is low, set by the
// single store port used per item; input stalls once the 4-entry queue fills.
// Synchronous active-low reset clears cursor state, lock count, registers to their
// defaults, and empties the pipeline.
module and_xor_cursor_overlay_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [15:0] i_pointer_x,
    input  logic signed [15:0] i_pointer_y,
    input  logic [5:0]         i_shape_col,
    input  logic [5:0]         i_shape_row,
    input  logic [31:0]        i_frame_pixel,
    input  logic [31:0]        i_xor_value,
    input  logic               i_mono_mode,
    input  logic               i_last_pixel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_pixel_out,
    output logic signed [15:0] o_target_x,
    output logic signed [15:0] o_target_y,
    output logic               o_write_enable,
    output logic               o_accepted,
    output logic [1:0]         o_cursor_state,
    output logic signed [15:0] o_rect_left,
    output logic signed [15:0] o_rect_top,
    output logic signed [15:0] o_rect_right,
    output logic signed [15:0] o_rect_bottom
);
    axco_pkg::t_job f_job, q_job;
    axco_pkg::t_res res;
    logic take, q_empty, q_full, pop, mrd, mwe;
    logic [axco_pkg::ADDR_BITS-1:0] mrd_addr;
    logic [31:0] and_rd, xor_rd;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign take        = i_valid && !q_full;
    assign mwe         = pop && q_job.load;

    axco_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_take(take), .i_opcode(i_opcode), .i_pointer_x(i_pointer_x),
        .i_pointer_y(i_pointer_y), .i_shape_col(i_shape_col), .i_shape_row(i_shape_row),
        .i_frame_pixel(i_frame_pixel), .i_xor_value(i_xor_value),
        .i_mono_mode(i_mono_mode), .i_last_pixel(i_last_pixel), .o_job(f_job),
        .i_mwe(mwe), .i_mw_and(q_job.fp), .i_mw_xor(q_job.xv),
        .i_mrd(mrd), .i_mrd_addr(mrd_addr), .o_and(and_rd), .o_xor(xor_rd));

    axco_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(take), .i_job(f_job),
        .i_pop(pop), .o_job(q_job), .o_empty(q_empty), .o_full(q_full));

    axco_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_qv(!q_empty), .i_job(q_job),
        .o_pop(pop), .o_mrd(mrd), .o_mrd_addr(mrd_addr), .i_and(and_rd),
        .i_xor(xor_rd), .i_stall(i_stall), .o_valid(o_valid), .o_res(res));

    assign o_pixel_out    = res.pixel;
    assign o_target_x     = res.tx;
    assign o_target_y     = res.ty;
    assign o_write_enable = res.we;
    assign o_accepted     = res.acc;
    assign o_cursor_state = res.state;
    assign o_rect_left    = res.rl;
    assign o_rect_top     = res.rt;
    assign o_rect_right   = res.rr;
    assign o_rect_bottom  = res.rb;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !take) else $error("push into full queue");
    a_we_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_enable |-> o_accepted) else $error("write without accept");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
endmodule

### sv/axco_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module axco_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/axco_front.sv
// Front part: configuration registers, cursor state, item classification
// and mask stores. Depends on axco_pkg and axco_ram.
module axco_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [2:0]                    i_cfg_index,
    input  logic [12:0]                   i_cfg_data,
    input  logic                          i_take,
    input  logic [2:0]                    i_opcode,
    input  logic signed [15:0]            i_pointer_x,
    input  logic signed [15:0]            i_pointer_y,
    input  logic [5:0]                    i_shape_col,
    input  logic [5:0]                    i_shape_row,
    input  logic [31:0]                   i_frame_pixel,
    input  logic [31:0]                   i_xor_value,
    input  logic                          i_mono_mode,
    input  logic                          i_last_pixel,
    output axco_pkg::t_job                o_job,
    input  logic                          i_mwe,
    input  logic [31:0]                   i_mw_and,
    input  logic [31:0]                   i_mw_xor,
    input  logic                          i_mrd,
    input  logic [axco_pkg::ADDR_BITS-1:0] i_mrd_addr,
    output logic [31:0]                   o_and,
    output logic [31:0]                   o_xor
);
    logic [12:0] r_scr_w, r_scr_h;
    logic [6:0]  r_cur_w, r_cur_h;
    logic [5:0]  r_hot_x, r_hot_y;
    logic [2:0]  r_bpp;
    logic [1:0]  r_state, n_state;
    logic [7:0]  r_lock, n_lock;
    axco_pkg::t_coord r_off_x, r_off_y, r_dx, r_dy, n_off_x, n_off_y, n_dx, n_dy;
    logic [axco_pkg::SIDE_BITS:0] r_dw, r_dh, n_dw, n_dh, w, h;
    logic [31:0] pm, and_w, xor_w;
    logic [axco_pkg::ADDR_BITS-1:0] addr;
    axco_pkg::t_coord bx, by, ex, ey;
    axco_pkg::t_job j;

    assign pm   = axco_pkg::pix_mask(r_bpp);
    assign w    = axco_pkg::side_lim(r_cur_w);
    assign h    = axco_pkg::side_lim(r_cur_h);
    assign addr = {i_shape_row, i_shape_col};
    assign and_w = i_mono_mode ? (i_frame_pixel[0] ? pm : '0) : (i_frame_pixel & pm);
    assign xor_w = i_mono_mode ? (i_xor_value[0] ? pm : '0) : (i_xor_value & pm);
    assign bx = r_off_x + axco_pkg::t_coord'(i_shape_col);
    assign by = r_off_y + axco_pkg::t_coord'(i_shape_row);
    assign ex = r_dx + axco_pkg::t_coord'(i_shape_col);
    assign ey = r_dy + axco_pkg::t_coord'(i_shape_row);

    axco_ram #(.WIDTH(32), .DEPTH(axco_pkg::DEPTH)) u_and (
        .i_clk(i_clk), .i_we(i_mwe), .i_waddr(i_mrd_addr), .i_wdata(i_mw_and),
        .i_re(i_mrd), .i_raddr(i_mrd_addr), .o_rdata(o_and));
    axco_ram #(.WIDTH(32), .DEPTH(axco_pkg::DEPTH)) u_xor (
        .i_clk(i_clk), .i_we(i_mwe), .i_waddr(i_mrd_addr), .i_wdata(i_mw_xor),
        .i_re(i_mrd), .i_raddr(i_mrd_addr), .o_rdata(o_xor));

    always_comb begin
        n_state = r_state; n_lock = r_lock;
        n_off_x = r_off_x; n_off_y = r_off_y;
        n_dx = r_dx; n_dy = r_dy; n_dw = r_dw; n_dh = r_dh;
        j = '0;
        j.addr = addr;
        j.fp   = i_frame_pixel;
        j.pm   = pm;
        case (i_opcode)
            axco_pkg::OP_LOAD: begin
                j.acc  = 1'b1;
                j.load = 1'b1;
                j.fp   = and_w;
                j.xv   = xor_w;
                if (i_last_pixel && r_state == axco_pkg::ST_EMPTY) begin
                    n_state = axco_pkg::ST_ERASED;
                end
            end
            axco_pkg::OP_POS: begin
                if (r_state != axco_pkg::ST_BLITTED) begin
                    j.acc = 1'b1;
                    n_off_x = i_pointer_x - axco_pkg::t_coord'(r_hot_x);
                    n_off_y = i_pointer_y - axco_pkg::t_coord'(r_hot_y);
                end
            end
            axco_pkg::OP_BLIT: begin
                if (r_state == axco_pkg::ST_ERASED && r_lock == 8'd0) begin
                    j.acc  = 1'b1;
                    j.blit = 1'b1;
                    j.tx = bx; j.ty = by;
                    j.hit = ({1'b0, i_shape_col} < w) && ({1'b0, i_shape_row} < h)
                        && !bx[15] && !by[15]
                        && ({1'b0, bx[14:0]} < {3'b0, r_scr_w})
                        && ({1'b0, by[14:0]} < {3'b0, r_scr_h});
                    if (i_last_pixel) begin
                        n_state = axco_pkg::ST_BLITTED;
                        n_dx = r_off_x; n_dy = r_off_y; n_dw = w; n_dh = h;
                        j.rl = r_off_x; j.rt = r_off_y;
                        j.rr = r_off_x + axco_pkg::t_coord'(w);
                        j.rb = r_off_y + axco_pkg::t_coord'(h);
                    end
                end
            end
            axco_pkg::OP_ERASE: begin
                if (r_state == axco_pkg::ST_BLITTED && r_lock == 8'd0) begin
                    j.acc   = 1'b1;
                    j.erase = 1'b1;
                    j.tx = ex; j.ty = ey;
                    j.hit = ({1'b0, i_shape_col} < r_dw) && ({1'b0, i_shape_row} < r_dh)
                        && !ex[15] && !ey[15]
                        && ({1'b0, ex[14:0]} < {3'b0, r_scr_w})
                        && ({1'b0, ey[14:0]} < {3'b0, r_scr_h});
                    if (i_last_pixel) begin
                        n_state = axco_pkg::ST_ERASED;
                        j.rl = r_dx; j.rt = r_dy;
                        j.rr = r_dx + axco_pkg::t_coord'(r_dw);
                        j.rb = r_dy + axco_pkg::t_coord'(r_dh);
                    end
                end
            end
            axco_pkg::OP_LOCK: begin
                j.acc = 1'b1;
                if (r_lock != 8'hFF) n_lock = r_lock + 8'd1;
            end
            axco_pkg::OP_UNLOCK: begin
                j.acc = 1'b1;
                if (r_lock != 8'd0) n_lock = r_lock - 8'd1;
            end
            axco_pkg::OP_UNLOAD: begin
                j.acc = 1'b1;
                n_state = axco_pkg::ST_EMPTY;
            end
            default: ;
        endcase
        j.state = n_state;
        o_job = j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 13'd640; r_scr_h <= 13'd480;
            r_cur_w <= 7'd32;   r_cur_h <= 7'd32;
            r_hot_x <= '0;      r_hot_y <= '0;
            r_bpp   <= 3'd4;
            r_state <= axco_pkg::ST_EMPTY;
            r_lock  <= '0;
            r_off_x <= '0; r_off_y <= '0; r_dx <= '0; r_dy <= '0;
            r_dw <= '0; r_dh <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    axco_pkg::REG_SCR_W: r_scr_w <= i_cfg_data;
                    axco_pkg::REG_SCR_H: r_scr_h <= i_cfg_data;
                    axco_pkg::REG_CUR_W: r_cur_w <= i_cfg_data[6:0];
                    axco_pkg::REG_CUR_H: r_cur_h <= i_cfg_data[6:0];
                    axco_pkg::REG_HOT_X: r_hot_x <= i_cfg_data[5:0];
                    axco_pkg::REG_HOT_Y: r_hot_y <= i_cfg_data[5:0];
                    axco_pkg::REG_BPP:   r_bpp   <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_take) begin
                r_state <= n_state; r_lock <= n_lock;
                r_off_x <= n_off_x; r_off_y <= n_off_y;
                r_dx <= n_dx; r_dy <= n_dy; r_dw <= n_dw; r_dh <= n_dh;
            end
        end
    end
endmodule

### sv/axco_queue.sv
// Short FIFO of classified items between front and back parts.
// Depends on axco_pkg.
module axco_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  axco_pkg::t_job i_job,
    input  logic           i_pop,
    output axco_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);
    axco_pkg::t_job r_q [axco_pkg::Q_DEPTH];
    logic [axco_pkg::Q_BITS-1:0] r_wp, r_rp;
    logic [axco_pkg::Q_BITS:0]   r_cnt;

    assign o_job   = r_q[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (axco_pkg::Q_BITS+1)'(axco_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (axco_pkg::Q_BITS+1)'(i_push) - (axco_pkg::Q_BITS+1)'(i_pop);
        end
    end
endmodule

### sv/axco_back.sv
// Back part: store reads, save-under update and pixel compose, output register.
// Depends on axco_pkg and axco_ram.
module axco_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_qv,
    input  axco_pkg::t_job                 i_job,
    output logic                           o_pop,
    output logic                           o_mrd,
    output logic [axco_pkg::ADDR_BITS-1:0] o_mrd_addr,
    input  logic [31:0]                    i_and,
    input  logic [31:0]                    i_xor,
    input  logic                           i_stall,
    output logic                           o_valid,
    output axco_pkg::t_res                 o_res
);
    logic           r_v1, r_ov;
    axco_pkg::t_job r_j1;
    axco_pkg::t_res r_res, res1;
    logic [31:0]    sv_rd;
    logic           adv1, out_free;

    assign out_free = !r_ov || !i_stall;
    assign adv1     = !r_v1 || out_free;
    assign o_pop    = i_qv && adv1;
    assign o_mrd    = o_pop;
    assign o_mrd_addr = i_job.addr;

    axco_ram #(.WIDTH(32), .DEPTH(axco_pkg::DEPTH)) u_save (
        .i_clk(i_clk), .i_we(o_pop && i_job.blit && i_job.hit), .i_waddr(i_job.addr),
        .i_wdata(i_job.fp & i_job.pm), .i_re(o_pop), .i_raddr(i_job.addr),
        .o_rdata(sv_rd));

    always_comb begin
        res1 = '0;
        res1.acc   = r_j1.acc;
        res1.state = r_j1.state;
        res1.rl = r_j1.rl; res1.rt = r_j1.rt; res1.rr = r_j1.rr; res1.rb = r_j1.rb;
        if (r_j1.blit || r_j1.erase) begin
            res1.tx = r_j1.tx; res1.ty = r_j1.ty;
        end
        if (r_j1.hit) begin
            res1.we = 1'b1;
            res1.pixel = r_j1.blit ? (((r_j1.fp & i_and) ^ i_xor) & r_j1.pm)
                                   : (sv_rd & r_j1.pm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_j1 <= i_job;
        if (r_v1 && out_free) r_res <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (adv1) r_v1 <= o_pop;
            if (out_free) r_ov <= r_v1;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
endmodule
